[rtl/pair_reaction_rule_matcher_defines.svh]
// Assertion macros for the pair reaction rule matcher.
// Expects i_clk and i_rst_n in the scope of the using module.
`ifndef PAIR_REACTION_RULE_MATCHER_DEFINES_SVH
`define PAIR_REACTION_RULE_MATCHER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PRRM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define PRRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prrm_pkg.sv]
// Types, constants and rule-match functions for the pair reaction rule matcher.
// No dependencies.
package prrm_pkg;

    localparam int RULE_SLOTS  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int TYPE_W      = 3;
    localparam int STATE_W     = 6;
    localparam int STATE_BITS  = 6;
    localparam int RULE_W      = 33;
    localparam int IDX_W       = 3;
    localparam int RULE_COUNT_DEF = 8;

    localparam logic [STATE_W-1:0] STATE_MASK = STATE_W'((1 << STATE_BITS) - 1);
    localparam logic [TYPE_W-1:0]  WILD_MIN   = 3'd6;

    typedef enum logic [1:0] {
        BOND_KEEP  = 2'd0,
        BOND_MAKE  = 2'd1,
        BOND_BREAK = 2'd2
    } t_bond_act;

    typedef struct packed {
        logic               valid;
        logic               new_bond;
        logic [STATE_W-1:0] new2;
        logic [STATE_W-1:0] new1;
        logic               need;
        logic [STATE_W-1:0] state2;
        logic [TYPE_W-1:0]  type2;
        logic [STATE_W-1:0] state1;
        logic [TYPE_W-1:0]  type1;
    } t_rule;

    typedef struct packed {
        logic [TYPE_W-1:0]  type1;
        logic [STATE_W-1:0] state1;
        logic [TYPE_W-1:0]  type2;
        logic [STATE_W-1:0] state2;
        logic               bonded;
    } t_query;

    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [STATE_W-1:0] n1;
        logic [STATE_W-1:0] n2;
        t_bond_act          act;
    } t_hit;

    typedef struct packed {
        t_hit fwd;
        t_hit swp;
    } t_carry;

    function automatic logic is_wild(input logic [TYPE_W-1:0] t);
        return t >= WILD_MIN;
    endfunction

    function automatic logic rule_hit(
        input t_rule              r,
        input logic [TYPE_W-1:0]  pt,
        input logic [STATE_W-1:0] ps,
        input logic [TYPE_W-1:0]  qt,
        input logic [STATE_W-1:0] qs,
        input logic               bonded
    );
        logic t1ok;
        logic t2ok;
        logic sok;
        sok  = ((r.state1 & STATE_MASK) == (ps & STATE_MASK))
            && ((r.state2 & STATE_MASK) == (qs & STATE_MASK));
        t1ok = (r.type1 == pt) || is_wild(r.type1);
        if (r.type2 == qt) begin
            t2ok = 1'b1;
        end else if (is_wild(r.type2)) begin
            t2ok = (r.type1 != r.type2) || (pt == qt);
        end else begin
            t2ok = 1'b0;
        end
        return r.valid && sok && t1ok && t2ok && (r.need == bonded);
    endfunction

    function automatic t_hit make_hit(input t_rule r, input logic [IDX_W-1:0] idx);
        t_hit h;
        h.hit = 1'b1;
        h.idx = idx;
        h.n1  = r.new1 & STATE_MASK;
        h.n2  = r.new2 & STATE_MASK;
        if (r.need && !r.new_bond) begin
            h.act = BOND_BREAK;
        end else if (!r.need && r.new_bond) begin
            h.act = BOND_MAKE;
        end else begin
            h.act = BOND_KEEP;
        end
        return h;
    endfunction

endpackage

[rtl/prrm_cell.sv]
// One rule cell: holds one rule word and one pipeline slot of the query chain.
// Depends on prrm_pkg.
module prrm_cell
    import prrm_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RULE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_query               i_query,
    input  t_carry               i_carry,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_query               o_query,
    output t_carry               o_carry
);

    t_rule  r_rule;
    logic   r_valid;
    t_query r_query;
    t_carry r_carry;
    t_carry n_carry;
    logic   w_fwd;
    logic   w_swp;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= '0;
        end else if (i_cfg_valid && (i_cfg_index == CFG_IDX_W'(CELL_IDX))) begin
            r_rule <= t_rule'(i_cfg_data);
        end
    end

    always_comb begin
        w_fwd = rule_hit(r_rule, i_query.type1, i_query.state1,
                         i_query.type2, i_query.state2, i_query.bonded);
        w_swp = rule_hit(r_rule, i_query.type2, i_query.state2,
                         i_query.type1, i_query.state1, i_query.bonded);
        n_carry = i_carry;
        if (!i_carry.fwd.hit && w_fwd) begin
            n_carry.fwd = make_hit(r_rule, IDX_W'(CELL_IDX));
        end
        if (!i_carry.swp.hit && w_swp) begin
            n_carry.swp = make_hit(r_rule, IDX_W'(CELL_IDX));
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_query <= i_query;
            r_carry <= n_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_query = r_query;
    assign o_carry = r_carry;

endmodule

[rtl/pair_reaction_rule_matcher.sv]
// Top level of the pair reaction rule matcher: chain of rule cells and result register.
// Depends on prrm_pkg, prrm_cell and pair_reaction_rule_matcher_defines.svh.
//
// Usage:
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes rule word
//   i_cfg_index into the cell that holds it; write only while no request is in flight.
//   Input channel (i_in_valid / o_in_ready) takes one atom pair per request.
//   Output channel (o_out_valid / i_out_ready) returns one result per request, in order.
//   The request walks one cell per cycle while not held by back-pressure; each cell
//   checks its rule in both atom orders and keeps the lowest-numbered hit per order.
//   The result register then picks the forward hit, else the swapped hit.
//   Throughput: one request per cycle while the receiver does not stall, set by the
//   one-register-per-cell chain.
//   Receiver stall: the result register holds; each cell keeps taking requests
//   while it or a later slot is empty, so bubbles close up before input stalls.
//   Reset: rule words clear to zero (no rule fires), all slots empty.
module pair_reaction_rule_matcher
    import prrm_pkg::*;
#(
    parameter int RULE_COUNT = RULE_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RULE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TYPE_W-1:0]    i_first_type,
    input  logic [STATE_W-1:0]   i_first_state,
    input  logic [TYPE_W-1:0]    i_second_type,
    input  logic [STATE_W-1:0]   i_second_state,
    input  logic                 i_pair_bonded,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_rule_matched,
    output logic [IDX_W-1:0]     o_matched_rule,
    output logic                 o_order_swapped,
    output logic [STATE_W-1:0]   o_first_state_next,
    output logic [STATE_W-1:0]   o_second_state_next,
    output logic [1:0]           o_bond_action
);

    `include "pair_reaction_rule_matcher_defines.svh"

    logic   w_valid [0:RULE_COUNT];
    logic   w_ready [0:RULE_COUNT];
    t_query w_query [0:RULE_COUNT];
    t_carry w_carry [0:RULE_COUNT];

    logic               r_out_valid;
    logic               r_matched;
    logic [IDX_W-1:0]   r_rule;
    logic               r_swapped;
    logic [STATE_W-1:0] r_s1;
    logic [STATE_W-1:0] r_s2;
    t_bond_act          r_act;

    logic               n_matched;
    logic [IDX_W-1:0]   n_rule;
    logic               n_swapped;
    logic [STATE_W-1:0] n_s1;
    logic [STATE_W-1:0] n_s2;
    t_bond_act          n_act;
    logic               w_out_take;

    assign o_cfg_ready = 1'b1;

    assign w_valid[0]        = i_in_valid;
    assign o_in_ready        = w_ready[0];
    assign w_query[0].type1  = i_first_type;
    assign w_query[0].state1 = i_first_state;
    assign w_query[0].type2  = i_second_type;
    assign w_query[0].state2 = i_second_state;
    assign w_query[0].bonded = i_pair_bonded;
    assign w_carry[0]        = '0;

    genvar k;
    generate
        for (k = 0; k < RULE_COUNT; k++) begin : g_cell
            prrm_cell #(
                .CELL_IDX(k)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cfg_valid (i_cfg_valid),
                .i_cfg_index (i_cfg_index),
                .i_cfg_data  (i_cfg_data),
                .i_valid     (w_valid[k]),
                .o_ready     (w_ready[k]),
                .i_query     (w_query[k]),
                .i_carry     (w_carry[k]),
                .o_valid     (w_valid[k+1]),
                .i_ready     (w_ready[k+1]),
                .o_query     (w_query[k+1]),
                .o_carry     (w_carry[k+1])
            );
        end
    endgenerate

    assign w_ready[RULE_COUNT] = !r_out_valid || i_out_ready;
    assign w_out_take          = w_valid[RULE_COUNT] && w_ready[RULE_COUNT];

    always_comb begin
        n_matched = 1'b0;
        n_rule    = '0;
        n_swapped = 1'b0;
        n_s1      = w_query[RULE_COUNT].state1 & STATE_MASK;
        n_s2      = w_query[RULE_COUNT].state2 & STATE_MASK;
        n_act     = BOND_KEEP;
        if (w_carry[RULE_COUNT].fwd.hit) begin
            n_matched = 1'b1;
            n_rule    = w_carry[RULE_COUNT].fwd.idx;
            n_s1      = w_carry[RULE_COUNT].fwd.n1;
            n_s2      = w_carry[RULE_COUNT].fwd.n2;
            n_act     = w_carry[RULE_COUNT].fwd.act;
        end else if (w_carry[RULE_COUNT].swp.hit) begin
            n_matched = 1'b1;
            n_rule    = w_carry[RULE_COUNT].swp.idx;
            n_swapped = 1'b1;
            n_s1      = w_carry[RULE_COUNT].swp.n2;
            n_s2      = w_carry[RULE_COUNT].swp.n1;
            n_act     = w_carry[RULE_COUNT].swp.act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take) begin
            r_matched <= n_matched;
            r_rule    <= n_rule;
            r_swapped <= n_swapped;
            r_s1      <= n_s1;
            r_s2      <= n_s2;
            r_act     <= n_act;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_rule_matched      = r_matched;
    assign o_matched_rule      = r_rule;
    assign o_order_swapped     = r_swapped;
    assign o_first_state_next  = r_s1;
    assign o_second_state_next = r_s2;
    assign o_bond_action       = r_act;

    `PRRM_ASSERT_ALWAYS(a_nomatch_clean, (!(o_out_valid && !o_rule_matched) || ((o_matched_rule == '0) && !o_order_swapped && (o_bond_action == BOND_KEEP))), "miss result carries rule data")
    `PRRM_ASSERT_ALWAYS(a_rule_in_range, (!(o_out_valid && o_rule_matched) || (int'(o_matched_rule) < RULE_COUNT)), "winning rule beyond rule count")
    `PRRM_ASSERT_NEXT(a_accept_lands, (i_in_valid && o_in_ready), w_valid[1], "accepted request missing from first cell")

endmodule

[tb/tb_top.sv]
// Testbench for pair_reaction_rule_matcher: loads rule tables, sends atom pair requests
// and checks every result against a local predictor of the rule search.
// Depends on prrm_pkg and the pair_reaction_rule_matcher RTL.
`timescale 1ns / 1ps

module tb_top;
    import prrm_pkg::*;

    localparam int RULES       = RULE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic               matched;
        logic [IDX_W-1:0]   rule;
        logic               swapped;
        logic [STATE_W-1:0] first_next;
        logic [STATE_W-1:0] second_next;
        t_bond_act          action;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [RULE_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [TYPE_W-1:0]    i_first_type = '0;
    logic [STATE_W-1:0]   i_first_state = '0;
    logic [TYPE_W-1:0]    i_second_type = '0;
    logic [STATE_W-1:0]   i_second_state = '0;
    logic                 i_pair_bonded = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_rule_matched;
    logic [IDX_W-1:0]     o_matched_rule;
    logic                 o_order_swapped;
    logic [STATE_W-1:0]   o_first_state_next;
    logic [STATE_W-1:0]   o_second_state_next;
    logic [1:0]           o_bond_action;

    t_rule    rule_table [RULES];
    t_outcome reaction_q [$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       stall_left = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    pair_reaction_rule_matcher dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_first_type        (i_first_type),
        .i_first_state       (i_first_state),
        .i_second_type       (i_second_type),
        .i_second_state      (i_second_state),
        .i_pair_bonded       (i_pair_bonded),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_rule_matched      (o_rule_matched),
        .o_matched_rule      (o_matched_rule),
        .o_order_swapped     (o_order_swapped),
        .o_first_state_next  (o_first_state_next),
        .o_second_state_next (o_second_state_next),
        .o_bond_action       (o_bond_action)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic any_type(input logic [TYPE_W-1:0] t);
        return t >= WILD_MIN;
    endfunction

    function automatic int find_rule(
        input logic [TYPE_W-1:0]  pt,
        input logic [STATE_W-1:0] ps,
        input logic [TYPE_W-1:0]  qt,
        input logic [STATE_W-1:0] qs,
        input logic               bonded
    );
        t_rule r;
        logic  t1ok;
        logic  t2ok;
        for (int i = 0; i < RULES; i++) begin
            r = rule_table[i];
            t1ok = (r.type1 == pt) || any_type(r.type1);
            if (r.type2 == qt) begin
                t2ok = 1'b1;
            end else if (any_type(r.type2)) begin
                t2ok = (r.type1 != r.type2) || (pt == qt);
            end else begin
                t2ok = 1'b0;
            end
            if (r.valid && r.state1 == ps && r.state2 == qs && t1ok && t2ok
                    && r.need == bonded) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_outcome predict_reaction(input t_query q);
        t_outcome o;
        t_rule    r;
        int       hit;
        logic     swapped;
        swapped = 1'b0;
        hit = find_rule(q.type1, q.state1, q.type2, q.state2, q.bonded);
        if (hit < 0) begin
            hit = find_rule(q.type2, q.state2, q.type1, q.state1, q.bonded);
            swapped = 1'b1;
        end
        if (hit < 0) begin
            o.matched     = 1'b0;
            o.rule        = '0;
            o.swapped     = 1'b0;
            o.first_next  = q.state1;
            o.second_next = q.state2;
            o.action      = BOND_KEEP;
        end else begin
            r = rule_table[hit];
            o.matched     = 1'b1;
            o.rule        = IDX_W'(hit);
            o.swapped     = swapped;
            o.first_next  = swapped ? r.new2 : r.new1;
            o.second_next = swapped ? r.new1 : r.new2;
            if (r.need && !r.new_bond) begin
                o.action = BOND_BREAK;
            end else if (!r.need && r.new_bond) begin
                o.action = BOND_MAKE;
            end else begin
                o.action = BOND_KEEP;
            end
        end
        return o;
    endfunction

    function automatic t_rule pack_rule(
        input int t1, input int s1, input int t2, input int s2, input int need,
        input int n1, input int n2, input int nb, input int valid
    );
        t_rule r;
        r.type1    = TYPE_W'(t1);
        r.state1   = STATE_W'(s1);
        r.type2    = TYPE_W'(t2);
        r.state2   = STATE_W'(s2);
        r.need     = need[0];
        r.new1     = STATE_W'(n1);
        r.new2     = STATE_W'(n2);
        r.new_bond = nb[0];
        r.valid    = valid[0];
        return r;
    endfunction

    function automatic t_rule random_rule();
        t_rule r;
        case ($urandom_range(19))
            0: r = '0;
            1: r = '1;
            default: begin
                r.type1    = TYPE_W'($urandom_range(7));
                r.state1   = STATE_W'($urandom_range(63));
                r.type2    = TYPE_W'($urandom_range(7));
                r.state2   = STATE_W'($urandom_range(63));
                r.need     = 1'($urandom_range(1));
                r.new1     = STATE_W'($urandom_range(63));
                r.new2     = STATE_W'($urandom_range(63));
                r.new_bond = 1'($urandom_range(1));
                r.valid    = ($urandom_range(9) != 0);
            end
        endcase
        return r;
    endfunction

    function automatic t_query random_pair();
        t_query             q;
        t_rule              r;
        logic [TYPE_W-1:0]  t;
        logic [STATE_W-1:0] s;
        q.type1  = TYPE_W'($urandom_range(7));
        q.state1 = STATE_W'($urandom_range(63));
        q.type2  = TYPE_W'($urandom_range(7));
        q.state2 = STATE_W'($urandom_range(63));
        q.bonded = 1'($urandom_range(1));
        if ($urandom_range(99) < 75) begin
            r = rule_table[$urandom_range(RULES - 1)];
            q.state1 = r.state1;
            q.state2 = r.state2;
            q.bonded = r.need;
            if (!any_type(r.type1)) begin
                q.type1 = r.type1;
            end
            if (r.type2 == r.type1 && any_type(r.type2)) begin
                q.type2 = q.type1;
            end else if (!any_type(r.type2)) begin
                q.type2 = r.type2;
            end
            if ($urandom_range(9) == 0) begin
                q.bonded = ~q.bonded;
            end
            if ($urandom_range(9) == 0) begin
                q.state2 = q.state2 ^ (STATE_W'(1) << $urandom_range(STATE_W - 1));
            end
            if ($urandom_range(1) == 1) begin
                t = q.type1;
                s = q.state1;
                q.type1  = q.type2;
                q.state1 = q.state2;
                q.type2  = t;
                q.state2 = s;
            end
        end
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // enter and leave at a falling edge
    task automatic write_rule(input int idx, input t_rule r);
        i_cfg_valid = 1'b1;
        i_cfg_index = CFG_IDX_W'(idx);
        i_cfg_data  = r;
        do @(posedge i_clk); while (!o_cfg_ready);
        rule_table[idx] = r;
        @(negedge i_clk);
    endtask

    task automatic offer_pair(input t_query q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_first_type   = q.type1;
        i_first_state  = q.state1;
        i_second_type  = q.type2;
        i_second_state = q.state2;
        i_pair_bonded  = q.bonded;
        do @(posedge i_clk); while (!o_in_ready);
        reaction_q = {reaction_q, predict_reaction(q)};
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (reaction_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_random_rules();
        t_rule r;
        t_rule older;
        for (int i = 0; i < RULES; i++) begin
            r = random_rule();
            if (i > 0 && $urandom_range(3) == 0) begin
                older = rule_table[$urandom_range(i - 1)];
                r.type1  = older.type1;
                r.state1 = older.state1;
                r.type2  = older.type2;
                r.state2 = older.state2;
                r.need   = older.need;
            end
            write_rule(i, r);
        end
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_empty_table();
        offer_pair('{3'd0, 6'd0, 3'd0, 6'd0, 1'b0});
        offer_pair('{3'd7, 6'd63, 3'd6, 6'd63, 1'b1});
        settle();
    endtask

    task automatic test_rule_cases();
        write_rule(0, pack_rule(7, 63, 7, 63, 1, 63, 63, 1, 1));
        write_rule(1, pack_rule(1, 5, 2, 9, 0, 10, 20, 1, 1));
        write_rule(2, pack_rule(3, 7, 4, 8, 0, 1, 2, 1, 0));
        write_rule(3, pack_rule(6, 1, 6, 2, 1, 3, 4, 0, 1));
        write_rule(4, pack_rule(6, 11, 7, 12, 0, 13, 14, 0, 1));
        write_rule(5, pack_rule(0, 20, 5, 21, 1, 22, 23, 1, 1));
        write_rule(6, pack_rule(0, 20, 5, 21, 1, 30, 31, 0, 1));
        write_rule(7, pack_rule(2, 9, 1, 5, 0, 42, 43, 0, 1));
        i_cfg_valid = 1'b0;
        offer_pair('{3'd1, 6'd5, 3'd2, 6'd9, 1'b0});
        offer_pair('{3'd2, 6'd9, 3'd1, 6'd5, 1'b0});
        offer_pair('{3'd1, 6'd5, 3'd2, 6'd9, 1'b1});
        offer_pair('{3'd3, 6'd7, 3'd4, 6'd8, 1'b0});
        offer_pair('{3'd4, 6'd1, 3'd4, 6'd2, 1'b1});
        offer_pair('{3'd4, 6'd1, 3'd5, 6'd2, 1'b1});
        offer_pair('{3'd7, 6'd1, 3'd7, 6'd2, 1'b1});
        offer_pair('{3'd2, 6'd11, 3'd5, 6'd12, 1'b0});
        offer_pair('{3'd7, 6'd11, 3'd6, 6'd12, 1'b0});
        offer_pair('{3'd0, 6'd20, 3'd5, 6'd21, 1'b1});
        offer_pair('{3'd5, 6'd21, 3'd0, 6'd20, 1'b1});
        offer_pair('{3'd6, 6'd20, 3'd5, 6'd21, 1'b1});
        offer_pair('{3'd3, 6'd63, 3'd3, 6'd63, 1'b1});
        offer_pair('{3'd3, 6'd63, 3'd4, 6'd63, 1'b1});
        offer_pair('{3'd0, 6'd0, 3'd0, 6'd0, 1'b0});
        settle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (4) begin
            load_random_rules();
            repeat (75) offer_pair(random_pair());
            settle();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random_rules();
        stall_left = 300;
        repeat (60) offer_pair(random_pair());
        settle();
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left  = stall_left - 1;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reaction_q.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = reaction_q.pop_front();
                if (o_rule_matched !== want.matched)
                    report_mismatch("rule_matched", int'(o_rule_matched),
                                    int'(want.matched));
                if (o_matched_rule !== want.rule)
                    report_mismatch("matched_rule", int'(o_matched_rule), int'(want.rule));
                if (o_order_swapped !== want.swapped)
                    report_mismatch("order_swapped", int'(o_order_swapped),
                                    int'(want.swapped));
                if (o_first_state_next !== want.first_next)
                    report_mismatch("first_state_next", int'(o_first_state_next),
                                    int'(want.first_next));
                if (o_second_state_next !== want.second_next)
                    report_mismatch("second_state_next", int'(o_second_state_next),
                                    int'(want.second_next));
                if (o_bond_action !== want.action)
                    report_mismatch("bond_action", int'(o_bond_action), int'(want.action));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < RULES; i++) begin
            rule_table[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_table();
        test_rule_cases();
        test_random_traffic(21, 70);
        test_random_traffic(70, 21);
        test_random_traffic(0, 0);
        test_backpressure();
        repeat (RULES + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/prrm_pkg.sv
rtl/prrm_cell.sv
rtl/pair_reaction_rule_matcher.sv
tb/tb_top.sv
